FILE: design/ilir_pkg.sv
// Package for the indexed list block: sizes, operation and status codes,
// and the command/status structs between controller and datapath.
// No dependencies.
package ilir_pkg;

	// Store geometry
	localparam int CAPACITY = 64;
	localparam int DATA_W   = 32;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int COUNT_W  = $clog2(CAPACITY + 1);

	// Field widths fixed by the interface
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// Operation codes
	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_GET    = 2'd1;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

	// Status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// Controller to datapath commands
	typedef struct packed {
		logic capture;    // latch the request beat
		logic eval;       // latch the status of the request
		logic start;      // load the shift cursor
		logic step;       // one shift move: read at cursor, advance
		logic read_pos;   // read the entry at the request position
		logic take_read;  // latch read data as result value
		logic write_elem; // write the element at the request position
		logic cnt_inc;
		logic cnt_dec;
		logic load_out;   // move the result into the output register
	} ilir_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic            ok;       // request status is ok
		logic [OP_W-1:0] op;       // latched operation
		logic            no_shift; // request touches the last slot only
		logic            last;     // cursor on the final move
		logic            out_free; // output register can take a result
	} ilir_stat_t;

endpackage

FILE: design/ilir_ctrl.sv
// Controller state machine for the indexed list block.
// Depends on ilir_pkg for the command and status structs and op codes.
module ilir_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  ilir_pkg::ilir_stat_t stat,
	output ilir_pkg::ilir_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EVAL  = 7'b0000010,
		S_SHIFT = 7'b0000100,
		S_DRAIN = 7'b0001000,
		S_ELEM  = 7'b0010000,
		S_GETW  = 7'b0100000,
		S_DONE  = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_nx;

	assign in_stall = (state_q != S_IDLE);

	// Next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nx    = S_EVAL;
				end
			end
			S_EVAL: begin
				cmd.eval = 1'b1;
				if (!stat.ok) begin
					state_nx = S_DONE;
				end else if (stat.op == ilir_pkg::OP_GET) begin
					cmd.read_pos = 1'b1;
					state_nx     = S_GETW;
				end else if (stat.op == ilir_pkg::OP_INSERT) begin
					if (stat.no_shift) begin
						state_nx = S_ELEM;
					end else begin
						cmd.start = 1'b1;
						state_nx  = S_SHIFT;
					end
				end else begin
					// remove
					if (stat.no_shift) begin
						cmd.cnt_dec = 1'b1;
						state_nx    = S_DONE;
					end else begin
						cmd.start = 1'b1;
						state_nx  = S_SHIFT;
					end
				end
			end
			S_SHIFT: begin
				cmd.step = 1'b1;
				if (stat.last) begin
					state_nx = S_DRAIN;
				end
			end
			S_DRAIN: begin
				// pending move is written here
				if (stat.op == ilir_pkg::OP_INSERT) begin
					state_nx = S_ELEM;
				end else begin
					cmd.cnt_dec = 1'b1;
					state_nx    = S_DONE;
				end
			end
			S_ELEM: begin
				cmd.write_elem = 1'b1;
				cmd.cnt_inc    = 1'b1;
				state_nx       = S_DONE;
			end
			S_GETW: begin
				cmd.take_read = 1'b1;
				state_nx      = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_nx     = S_IDLE;
				end
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

endmodule

FILE: design/ilir_dp.sv
// Datapath for the indexed list block: entry memory, entry count, shift
// cursor, result and output registers. Depends on ilir_pkg.
module ilir_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  ilir_pkg::ilir_cmd_t               cmd,
	output ilir_pkg::ilir_stat_t              stat,
	input  logic [ilir_pkg::OP_W-1:0]         operation,
	input  logic [ilir_pkg::COUNT_W-1:0]      position,
	input  logic [ilir_pkg::DATA_W-1:0]       element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ilir_pkg::STATUS_W-1:0]     status,
	output logic [ilir_pkg::DATA_W-1:0]       read_value,
	output logic [ilir_pkg::COUNT_W-1:0]      list_size
);

	localparam int AW = ilir_pkg::ADDR_W;
	localparam int CW = ilir_pkg::COUNT_W;
	localparam int DW = ilir_pkg::DATA_W;

	// Request registers
	logic [ilir_pkg::OP_W-1:0] op_q;
	logic [CW-1:0]             pos_q;
	logic [DW-1:0]             elem_q;

	// List state
	logic [CW-1:0] count_q;
	logic [AW-1:0] cur_q;
	logic          pend_q;
	logic [AW-1:0] pend_addr_q;

	// Memory
	logic [DW-1:0] mem_q [ilir_pkg::CAPACITY];
	logic [DW-1:0] rd_data_q;
	logic [AW-1:0] rd_addr;

	// Result and output registers
	logic [ilir_pkg::STATUS_W-1:0] res_status_q;
	logic [DW-1:0]                 res_value_q;
	logic                          out_valid_q;
	logic [ilir_pkg::STATUS_W-1:0] status_q;
	logic [DW-1:0]                 read_value_q;
	logic [CW-1:0]                 list_size_q;

	logic [ilir_pkg::STATUS_W-1:0] req_status;
	logic                          is_insert;

	assign is_insert = (op_q == ilir_pkg::OP_INSERT);

	// Request status from the latched request and current count
	always_comb begin
		case (op_q)
			ilir_pkg::OP_INSERT: begin
				if (pos_q > count_q) begin
					req_status = ilir_pkg::ST_RANGE;
				end else if (count_q == CW'(ilir_pkg::CAPACITY)) begin
					req_status = ilir_pkg::ST_FULL;
				end else begin
					req_status = ilir_pkg::ST_OK;
				end
			end
			ilir_pkg::OP_GET, ilir_pkg::OP_REMOVE: begin
				req_status = (pos_q < count_q) ? ilir_pkg::ST_OK : ilir_pkg::ST_RANGE;
			end
			default: begin
				req_status = ilir_pkg::ST_RANGE;
			end
		endcase
	end

	// Status back to the controller
	always_comb begin
		stat.ok       = (req_status == ilir_pkg::ST_OK);
		stat.op       = op_q;
		stat.no_shift = is_insert ? (pos_q == count_q) : ((pos_q + CW'(1)) == count_q);
		stat.last     = is_insert ? (cur_q == pos_q[AW-1:0])
		                          : ({1'b0, cur_q} == (count_q - CW'(1)));
		stat.out_free = !out_valid_q || !out_stall;
	end

	// Request capture
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= operation;
			pos_q  <= position;
			elem_q <= element;
		end
	end

	// Entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.cnt_inc) begin
			count_q <= count_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			count_q <= count_q - CW'(1);
		end
	end

	// Shift cursor: insert walks down from the top, remove walks up
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			cur_q <= is_insert ? AW'(count_q - CW'(1)) : AW'(pos_q + CW'(1));
		end else if (cmd.step) begin
			cur_q       <= is_insert ? (cur_q - AW'(1)) : (cur_q + AW'(1));
			pend_addr_q <= is_insert ? (cur_q + AW'(1)) : (cur_q - AW'(1));
		end
	end

	// Pending move: read data of the previous step is written next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else begin
			pend_q <= cmd.step;
		end
	end

	assign rd_addr = cmd.read_pos ? pos_q[AW-1:0] : cur_q;

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (pend_q) begin
			mem_q[pend_addr_q] <= rd_data_q;
		end else if (cmd.write_elem) begin
			mem_q[pos_q[AW-1:0]] <= elem_q;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	// Result registers
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			res_status_q <= req_status;
			res_value_q  <= '0;
		end else if (cmd.take_read) begin
			res_value_q <= rd_data_q;
		end
	end

	// Output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			status_q     <= res_status_q;
			read_value_q <= res_value_q;
			list_size_q  <= count_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign status     = status_q;
	assign read_value = read_value_q;
	assign list_size  = list_size_q;

endmodule

FILE: design/indexed_list_insert_remove.sv
// Indexed list: ordered list of 32-bit entries in a 64-entry store.
// Input beat: operation (insert, get, remove), position, element.
// Output beat: status, read_value (get only), list_size after the request.
//
// Both channels use valid/stall; a beat moves when valid is high and stall
// is low. One result beat per request, in request order.
// The shift loop moves one entry per cycle through the single-write,
// registered-read entry memory.
// A new request is taken in the cycle after the previous result is loaded,
// even while that result still waits on a stalled receiver; a result that
// finds the output register still occupied waits inside the block.
// Reset empties the list and clears out_valid; entry contents are not
// cleared and need no clearing pass, since only written entries are read.
// Depends on ilir_pkg, ilir_ctrl and ilir_dp.
module indexed_list_insert_remove (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [ilir_pkg::OP_W-1:0]         operation,
	input  logic [ilir_pkg::COUNT_W-1:0]      position,
	input  logic [ilir_pkg::DATA_W-1:0]       element,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [ilir_pkg::STATUS_W-1:0]     status,
	output logic [ilir_pkg::DATA_W-1:0]       read_value,
	output logic [ilir_pkg::COUNT_W-1:0]      list_size
);

	ilir_pkg::ilir_cmd_t  cmd;
	ilir_pkg::ilir_stat_t stat;

	// Sequencer
	ilir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Storage and result path
	ilir_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.operation  (operation),
		.position   (position),
		.element    (element),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.list_size  (list_size)
	);

endmodule

FILE: tb/indexed_list_insert_remove_tb.sv
// Testbench for indexed_list_insert_remove: a shadow copy of the list predicts
// every result beat, and directed and random insert, get, remove and bad-code traffic checks it.
// Depends on ilir_pkg and the indexed_list_insert_remove RTL.
module indexed_list_insert_remove_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Operation code that the block must reject
	localparam logic [ilir_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

	localparam int unsigned HOLD_CYCLES = 400;
	localparam int unsigned DRAIN_LIMIT = 20000;

	typedef struct packed {
		logic [ilir_pkg::STATUS_W-1:0] status;
		logic [ilir_pkg::DATA_W-1:0]   read_value;
		logic [ilir_pkg::COUNT_W-1:0]  list_size;
	} list_result_t;

	// Shadow of the list contents; predicts and checks result beats
	class list_shadow;
		logic [ilir_pkg::DATA_W-1:0] entries [ilir_pkg::CAPACITY];
		int unsigned                 n_entries;
		list_result_t                pending_results [$];
		int unsigned                 failures;

		function new();
			n_entries = 0;
			failures = 0;
		endfunction

		function int unsigned list_len();
			return n_entries;
		endfunction

		function int unsigned pending();
			return pending_results.size();
		endfunction

		// Apply one accepted request beat and queue the result it causes
		function void apply_request(logic [ilir_pkg::OP_W-1:0] op,
				logic [ilir_pkg::COUNT_W-1:0] pos, logic [ilir_pkg::DATA_W-1:0] elem);
			list_result_t res;
			int           i;
			int           p;
			res.status = ilir_pkg::ST_OK;
			res.read_value = '0;
			p = int'(pos);
			case (op)
				ilir_pkg::OP_INSERT: begin
					// range check comes before the full check
					if (p > int'(n_entries)) begin
						res.status = ilir_pkg::ST_RANGE;
					end else if (n_entries >= ilir_pkg::CAPACITY) begin
						res.status = ilir_pkg::ST_FULL;
					end else begin
						for (i = int'(n_entries); i > p; i--)
							entries[i] = entries[i-1];
						entries[p] = elem;
						n_entries++;
					end
				end
				ilir_pkg::OP_GET: begin
					if (p >= int'(n_entries))
						res.status = ilir_pkg::ST_RANGE;
					else
						res.read_value = entries[p];
				end
				ilir_pkg::OP_REMOVE: begin
					if (p >= int'(n_entries)) begin
						res.status = ilir_pkg::ST_RANGE;
					end else begin
						for (i = p; i + 1 < int'(n_entries); i++)
							entries[i] = entries[i+1];
						n_entries--;
					end
				end
				default: res.status = ilir_pkg::ST_RANGE;
			endcase
			res.list_size = n_entries[ilir_pkg::COUNT_W-1:0];
			pending_results.push_back(res);
		endfunction

		function void note_mismatch(string field, logic [ilir_pkg::DATA_W-1:0] want,
				logic [ilir_pkg::DATA_W-1:0] got);
			failures++;
			$display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
		endfunction

		// Compare one accepted result beat with the oldest prediction
		function void check_result(list_result_t got);
			list_result_t want;
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result, expected none actual %0h %0h %0h",
					$time, got.status, got.read_value, got.list_size);
				return;
			end
			want = pending_results.pop_front();
			if (got.status !== want.status)
				note_mismatch("status", ilir_pkg::DATA_W'(want.status),
					ilir_pkg::DATA_W'(got.status));
			if (got.read_value !== want.read_value)
				note_mismatch("read_value", want.read_value, got.read_value);
			if (got.list_size !== want.list_size)
				note_mismatch("list_size", ilir_pkg::DATA_W'(want.list_size),
					ilir_pkg::DATA_W'(got.list_size));
		endfunction

		function bit clean();
			if (pending_results.size() != 0)
				$display("%0t: %0d results never arrived", $time, pending_results.size());
			return failures == 0 && pending_results.size() == 0;
		endfunction
	endclass

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic [ilir_pkg::OP_W-1:0]     operation = '0;
	logic [ilir_pkg::COUNT_W-1:0]  position = '0;
	logic [ilir_pkg::DATA_W-1:0]   element = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic [ilir_pkg::STATUS_W-1:0] status;
	logic [ilir_pkg::DATA_W-1:0]   read_value;
	logic [ilir_pkg::COUNT_W-1:0]  list_size;

	list_shadow  shadow = new();
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	logic        hold_trig = 1'b0;
	logic        hold_seen = 1'b0;
	int unsigned hold_left = 0;

	indexed_list_insert_remove i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.operation  (operation),
		.position   (position),
		.element    (element),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.list_size  (list_size)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver: check result beats, stall at random or hold off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_result('{status: status, read_value: read_value,
				list_size: list_size});
		if (hold_trig != hold_seen) begin
			hold_seen = hold_trig;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Offer one request beat after a random gap and wait until it is taken
	task automatic send_request(input logic [ilir_pkg::OP_W-1:0] op,
			input logic [ilir_pkg::COUNT_W-1:0] pos,
			input logic [ilir_pkg::DATA_W-1:0] elem);
		int unsigned gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		position <= pos;
		element <= elem;
		do
			@(posedge clk);
		while (!(in_valid && !in_stall));
		shadow.apply_request(op, pos, elem);
	endtask

	// Stop offering and wait for every predicted result
	task automatic wait_drained();
		int unsigned waited;
		in_valid <= 1'b0;
		waited = 0;
		while (shadow.pending() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		@(posedge clk);
	endtask

	// Random traffic in stretches that lean toward filling, draining or mixing
	task automatic run_random(input int unsigned n_items);
		int unsigned                  i;
		int unsigned                  left;
		int unsigned                  lean;
		int unsigned                  ins_w;
		int unsigned                  get_w;
		int unsigned                  r;
		int unsigned                  len;
		logic [ilir_pkg::OP_W-1:0]    op;
		logic [ilir_pkg::COUNT_W-1:0] pos;
		logic [ilir_pkg::DATA_W-1:0]  elem;
		left = 0;
		lean = 0;
		for (i = 0; i < n_items; i++) begin
			if (left == 0) begin
				left = $urandom_range(160, 60);
				lean = $urandom_range(2);
			end
			left--;
			case (lean)
				0: begin ins_w = 65; get_w = 15; end
				1: begin ins_w = 15; get_w = 20; end
				default: begin ins_w = 35; get_w = 30; end
			endcase
			r = $urandom_range(99);
			if (r < ins_w)
				op = ilir_pkg::OP_INSERT;
			else if (r < ins_w + get_w)
				op = ilir_pkg::OP_GET;
			else if (r < 97)
				op = ilir_pkg::OP_REMOVE;
			else
				op = OP_UNUSED;
			case ($urandom_range(9))
				0: elem = '0;
				1: elem = '1;
				default: elem = $urandom;
			endcase
			len = shadow.list_len();
			if ($urandom_range(99) < 12) begin
				pos = ilir_pkg::COUNT_W'($urandom_range(127));
			end else if (op == ilir_pkg::OP_INSERT) begin
				// prepend, append or anywhere in between
				case ($urandom_range(3))
					0: pos = '0;
					1: pos = ilir_pkg::COUNT_W'(len);
					default: pos = ilir_pkg::COUNT_W'($urandom_range(len));
				endcase
			end else if (len == 0) begin
				pos = '0;
			end else begin
				case ($urandom_range(3))
					0: pos = '0;
					1: pos = ilir_pkg::COUNT_W'(len - 1);
					default: pos = ilir_pkg::COUNT_W'($urandom_range(len - 1));
				endcase
			end
			send_request(op, pos, elem);
		end
	endtask

	initial begin
		int i;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty-list errors, prepend/append/middle, bad codes, removes
		send_idle_pct = 27;
		recv_idle_pct <= 55;
		send_request(ilir_pkg::OP_GET, 7'd0, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
		send_request(ilir_pkg::OP_INSERT, 7'd1, $urandom);
		send_request(ilir_pkg::OP_INSERT, 7'd0, 32'hFFFF_FFFF);
		send_request(ilir_pkg::OP_INSERT, 7'd1, 32'h0000_0000);
		send_request(ilir_pkg::OP_INSERT, 7'd0, 32'hA5A5_5A5A);
		send_request(ilir_pkg::OP_INSERT, 7'd2, 32'h1234_5678);
		for (i = 0; i < 5; i++)
			send_request(ilir_pkg::OP_GET, ilir_pkg::COUNT_W'(i), $urandom);
		send_request(OP_UNUSED, 7'd0, $urandom);
		send_request(ilir_pkg::OP_INSERT, 7'd127, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd3, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
		send_request(ilir_pkg::OP_GET, 7'd0, $urandom);
		send_request(ilir_pkg::OP_GET, 7'd1, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd2, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
		send_request(ilir_pkg::OP_REMOVE, 7'd0, $urandom);
		send_request(ilir_pkg::OP_GET, 7'd0, $urandom);

		// Sender idles less than the receiver; long receiver hold midway
		run_random(250);
		hold_trig <= ~hold_trig;
		run_random(300);
		wait_drained();

		// Receiver idles less than the sender
		send_idle_pct = 55;
		recv_idle_pct <= 27;
		run_random(270);
		wait_drained();
		run_random(270);
		wait_drained();

		// Back to back, with one more long receiver hold
		send_idle_pct = 0;
		recv_idle_pct <= 0;
		run_random(250);
		hold_trig <= ~hold_trig;
		run_random(250);

		wait_drained();
		repeat (100) @(posedge clk);
		if (shadow.clean())
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

endmodule

FILE: files.f
design/ilir_pkg.sv
design/ilir_ctrl.sv
design/ilir_dp.sv
design/indexed_list_insert_remove.sv
tb/indexed_list_insert_remove_tb.sv
